// File: src/euler_to_quaternion_top_assert.svh
// Assertion macros shared by the euler_to_quaternion RTL.
// Each macro expects i_clk and i_rst_n in the scope of the module that uses it.
`ifndef EULER_TO_QUATERNION_TOP_ASSERT_SVH
`define EULER_TO_QUATERNION_TOP_ASSERT_SVH

// Condition must never hold while out of reset.
`define E2Q_ASSERT_NEVER(label, cond, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) !(cond)) \
        else $error(msg);

// Consequent must hold in the same cycle as the antecedent.
`define E2Q_ASSERT_IMPLY(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define E2Q_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: src/e2q_pkg.sv
// Shared constants, types and helper functions of the Euler-to-quaternion block.
// No dependencies; every other file of the block but the assertion header refers to it by scoped names.
package e2q_pkg;

    // angle quantization
    localparam int SINE_TABLE_BITS = 10;
    localparam int ANGLE_W         = 16;
    localparam int PHASE_MULT_W    = 31;
    localparam int PROD_W          = ANGLE_W + PHASE_MULT_W;
    localparam int PHASE_SHIFT     = 45 - SINE_TABLE_BITS;
    localparam int PHASE_MSB       = PHASE_SHIFT + SINE_TABLE_BITS - 1;
    // round(2^32 / (2*pi)) : radians to 2^-32 turn
    localparam logic signed [PHASE_MULT_W-1:0] PHASE_MULT = PHASE_MULT_W'(683565276);
    localparam logic signed [PROD_W-1:0]       PHASE_ROUND =
        PROD_W'(1) << (PHASE_SHIFT - 1);

    // CORDIC
    localparam int CORDIC_STEPS = 16;
    localparam int CW           = 34;
    localparam int Z_W          = 30;
    localparam int RESID_LSB    = 32 - SINE_TABLE_BITS;
    localparam int SC_SHIFT     = 16;
    localparam logic signed [CW-1:0] CORDIC_X0 = CW'(652032874);
    localparam logic signed [CW-1:0] SC_ROUND  = CW'(1) << (SC_SHIFT - 1);
    localparam logic signed [CW-1:0] ATAN_TURNS [CORDIC_STEPS] = '{
        CW'(536870912), CW'(316933406), CW'(167458907), CW'(85004756),
        CW'(42667331),  CW'(21354465),  CW'(10680862),  CW'(5340245),
        CW'(2670163),   CW'(1335087),   CW'(667544),    CW'(333772),
        CW'(166886),    CW'(83443),     CW'(41722),     CW'(20861)
    };

    // products and result
    localparam int SC_W    = 16;
    localparam int QUAT_W  = 16;
    localparam int P1_W    = 2 * SC_W;
    localparam int P2_W    = P1_W + SC_W;
    localparam int SUM_W   = P2_W + 1;
    localparam int Q_SHIFT = 28;
    localparam logic signed [SUM_W-1:0] Q_ROUND    = SUM_W'(1) << (Q_SHIFT - 1);
    localparam logic signed [SUM_W-1:0] Q_ONE_WIDE = SUM_W'(16384);
    localparam logic signed [SC_W-1:0]  Q_ONE_SC   = SC_W'(16384);

    // front-to-back queue
    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CW    = QUEUE_AW + 1;

    typedef struct packed {
        logic [SINE_TABLE_BITS-1:0] roll;
        logic [SINE_TABLE_BITS-1:0] yaw;
        logic [SINE_TABLE_BITS-1:0] pitch;
    } t_angles;

    typedef struct packed {
        logic full;
        logic empty;
    } t_queue_status;

    // saturate to plus or minus one in Q1.14
    function automatic logic signed [SC_W-1:0] clamp_one(input logic signed [SUM_W-1:0] v);
        logic signed [SC_W-1:0] res;
        if (v > Q_ONE_WIDE) begin
            res = Q_ONE_SC;
        end else if (v < -Q_ONE_WIDE) begin
            res = -Q_ONE_SC;
        end else begin
            res = v[SC_W-1:0];
        end
        return res;
    endfunction

endpackage

// File: src/e2q_front.sv
// Front end: accepts angle words, scales them to turns and forms the phase indices.
// Depends on e2q_pkg; feeds e2q_fifo.
module e2q_front (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_valid,
    output logic                                 o_stall,
    input  logic signed [e2q_pkg::ANGLE_W-1:0]   i_roll_angle,
    input  logic signed [e2q_pkg::ANGLE_W-1:0]   i_yaw_angle,
    input  logic signed [e2q_pkg::ANGLE_W-1:0]   i_pitch_angle,
    input  e2q_pkg::t_queue_status               i_queue,
    output logic                                 o_push,
    output e2q_pkg::t_angles                     o_data
);

    logic                                r_valid;
    logic                                n_valid;
    logic signed [e2q_pkg::PROD_W-1:0]   r_prod_roll;
    logic signed [e2q_pkg::PROD_W-1:0]   r_prod_yaw;
    logic signed [e2q_pkg::PROD_W-1:0]   r_prod_pitch;
    logic signed [e2q_pkg::PROD_W-1:0]   w_sum_roll;
    logic signed [e2q_pkg::PROD_W-1:0]   w_sum_yaw;
    logic signed [e2q_pkg::PROD_W-1:0]   w_sum_pitch;
    logic                                w_accept;

    // hold the input while the staged word cannot enter the queue
    assign o_stall  = r_valid && i_queue.full;
    assign w_accept = i_valid && !o_stall;
    assign o_push   = r_valid && !i_queue.full;

    always_comb begin
        n_valid = r_valid;
        if (w_accept) begin
            n_valid = 1'b1;
        end else if (o_push) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    // half angle in turns: the factor one half is folded into the shift
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_prod_roll  <= i_roll_angle * e2q_pkg::PHASE_MULT;
            r_prod_yaw   <= i_yaw_angle * e2q_pkg::PHASE_MULT;
            r_prod_pitch <= i_pitch_angle * e2q_pkg::PHASE_MULT;
        end
    end

    // round half up, keep the index modulo one turn
    assign w_sum_roll  = r_prod_roll + e2q_pkg::PHASE_ROUND;
    assign w_sum_yaw   = r_prod_yaw + e2q_pkg::PHASE_ROUND;
    assign w_sum_pitch = r_prod_pitch + e2q_pkg::PHASE_ROUND;

    assign o_data.roll  = w_sum_roll[e2q_pkg::PHASE_MSB:e2q_pkg::PHASE_SHIFT];
    assign o_data.yaw   = w_sum_yaw[e2q_pkg::PHASE_MSB:e2q_pkg::PHASE_SHIFT];
    assign o_data.pitch = w_sum_pitch[e2q_pkg::PHASE_MSB:e2q_pkg::PHASE_SHIFT];

endmodule

// File: src/e2q_fifo.sv
// Short queue of phase-index words between the front end and the back end.
// Depends on e2q_pkg and euler_to_quaternion_top_assert.svh.
`include "euler_to_quaternion_top_assert.svh"

module e2q_fifo (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_push,
    input  e2q_pkg::t_angles         i_data,
    input  logic                     i_pop,
    output e2q_pkg::t_angles         o_head,
    output e2q_pkg::t_queue_status   o_status
);

    e2q_pkg::t_angles                  r_mem [e2q_pkg::QUEUE_DEPTH];
    logic [e2q_pkg::QUEUE_AW-1:0]      r_wr_ptr;
    logic [e2q_pkg::QUEUE_AW-1:0]      r_rd_ptr;
    logic [e2q_pkg::QUEUE_CW-1:0]      r_count;
    logic [e2q_pkg::QUEUE_CW-1:0]      n_count;

    assign o_status.full  = (r_count == e2q_pkg::QUEUE_CW'(e2q_pkg::QUEUE_DEPTH));
    assign o_status.empty = (r_count == '0);
    assign o_head         = r_mem[r_rd_ptr];

    always_comb begin
        n_count = r_count;
        if (i_push && !i_pop) begin
            n_count = r_count + 1'b1;
        end else if (i_pop && !i_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_count <= n_count;
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    `E2Q_ASSERT_NEVER(a_no_overflow, i_push && o_status.full && !i_pop, "push into full queue")
    `E2Q_ASSERT_NEVER(a_no_underflow, i_pop && o_status.empty, "pop from empty queue")
    `E2Q_ASSERT_NEXT(a_count_up, i_push && !i_pop, r_count == $past(r_count) + 1'b1, "count lost a push")

endmodule

// File: src/e2q_cordic.sv
// One CORDIC lane: sine and cosine in Q1.14 of a phase index, one iteration per stage.
// Depends on e2q_pkg; three instances sit in e2q_back.
module e2q_cordic (
    input  logic                                      i_clk,
    input  logic                                      i_en,
    input  logic [e2q_pkg::SINE_TABLE_BITS-1:0]       i_phase,
    output logic signed [e2q_pkg::SC_W-1:0]           o_sin,
    output logic signed [e2q_pkg::SC_W-1:0]           o_cos
);

    localparam int B     = e2q_pkg::SINE_TABLE_BITS;
    localparam int STEPS = e2q_pkg::CORDIC_STEPS;
    localparam int CW    = e2q_pkg::CW;

    typedef enum logic [1:0] {QUAD_I, QUAD_II, QUAD_III, QUAD_IV} t_quad;

    logic signed [CW-1:0] c_x [STEPS];
    logic signed [CW-1:0] c_y [STEPS];
    logic signed [CW-1:0] c_z [STEPS];
    logic [1:0]           c_q [STEPS];
    logic signed [CW-1:0] r_x [STEPS];
    logic signed [CW-1:0] r_y [STEPS];
    logic signed [CW-1:0] r_z [STEPS];
    logic [1:0]           r_q [STEPS];

    logic signed [CW-1:0]             w_cr;
    logic signed [CW-1:0]             w_sr;
    logic signed [CW-1:0]             w_cr_sh;
    logic signed [CW-1:0]             w_sr_sh;
    logic signed [e2q_pkg::SC_W-1:0]  n_cos;
    logic signed [e2q_pkg::SC_W-1:0]  n_sin;
    logic signed [e2q_pkg::SC_W-1:0]  r_cos;
    logic signed [e2q_pkg::SC_W-1:0]  r_sin;

    for (genvar gi = 0; gi < STEPS; gi++) begin : g_stage
        if (gi == 0) begin : g_first
            // residual within the quadrant, in 2^-32 turn
            assign c_x[gi] = e2q_pkg::CORDIC_X0;
            assign c_y[gi] = '0;
            assign c_z[gi] = {{(CW - e2q_pkg::Z_W){1'b0}}, i_phase[B-3:0],
                              {e2q_pkg::RESID_LSB{1'b0}}};
            assign c_q[gi] = i_phase[B-1:B-2];
        end else begin : g_next
            assign c_x[gi] = r_x[gi-1];
            assign c_y[gi] = r_y[gi-1];
            assign c_z[gi] = r_z[gi-1];
            assign c_q[gi] = r_q[gi-1];
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_q[gi] <= c_q[gi];
                if (!c_z[gi][CW-1]) begin
                    r_x[gi] <= c_x[gi] - (c_y[gi] >>> gi);
                    r_y[gi] <= c_y[gi] + (c_x[gi] >>> gi);
                    r_z[gi] <= c_z[gi] - e2q_pkg::ATAN_TURNS[gi];
                end else begin
                    r_x[gi] <= c_x[gi] + (c_y[gi] >>> gi);
                    r_y[gi] <= c_y[gi] - (c_x[gi] >>> gi);
                    r_z[gi] <= c_z[gi] + e2q_pkg::ATAN_TURNS[gi];
                end
            end
        end
    end

    // map back to the full circle, then round Q2.30 to Q1.14
    always_comb begin
        case (t_quad'(r_q[STEPS-1]))
            QUAD_I: begin
                w_cr = r_x[STEPS-1];
                w_sr = r_y[STEPS-1];
            end
            QUAD_II: begin
                w_cr = -r_y[STEPS-1];
                w_sr = r_x[STEPS-1];
            end
            QUAD_III: begin
                w_cr = -r_x[STEPS-1];
                w_sr = -r_y[STEPS-1];
            end
            default: begin
                w_cr = r_y[STEPS-1];
                w_sr = -r_x[STEPS-1];
            end
        endcase
        w_cr_sh = (w_cr + e2q_pkg::SC_ROUND) >>> e2q_pkg::SC_SHIFT;
        w_sr_sh = (w_sr + e2q_pkg::SC_ROUND) >>> e2q_pkg::SC_SHIFT;
        n_cos   = e2q_pkg::clamp_one(e2q_pkg::SUM_W'(w_cr_sh));
        n_sin   = e2q_pkg::clamp_one(e2q_pkg::SUM_W'(w_sr_sh));
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_cos <= n_cos;
            r_sin <= n_sin;
        end
    end

    assign o_cos = r_cos;
    assign o_sin = r_sin;

endmodule

// File: src/e2q_back.sv
// Back end: three CORDIC lanes, triple products, rounding and the output register.
// Depends on e2q_pkg, e2q_cordic and euler_to_quaternion_top_assert.svh.
`include "euler_to_quaternion_top_assert.svh"

module e2q_back (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  e2q_pkg::t_angles                      i_head,
    input  e2q_pkg::t_queue_status                i_queue,
    output logic                                  o_pop,
    output logic                                  o_valid,
    input  logic                                  i_stall,
    output logic signed [e2q_pkg::QUAT_W-1:0]     o_quat_x,
    output logic signed [e2q_pkg::QUAT_W-1:0]     o_quat_y,
    output logic signed [e2q_pkg::QUAT_W-1:0]     o_quat_z,
    output logic signed [e2q_pkg::QUAT_W-1:0]     o_quat_w
);

    // CORDIC stages, rounding stage, two product stages
    localparam int PIPE_DEPTH = e2q_pkg::CORDIC_STEPS + 3;
    localparam int SC_W  = e2q_pkg::SC_W;
    localparam int P1_W  = e2q_pkg::P1_W;
    localparam int P2_W  = e2q_pkg::P2_W;
    localparam int SUM_W = e2q_pkg::SUM_W;

    logic                      w_en;
    logic [PIPE_DEPTH-1:0]     r_vld;
    logic                      r_out_valid;

    logic signed [SC_W-1:0]    w_sr, w_cr, w_sy, w_cy, w_sp, w_cp;
    logic signed [SC_W-1:0]    r_sr, r_cr;
    logic signed [P1_W-1:0]    r_cycp, r_sysp, r_sycp, r_cysp;
    logic signed [P2_W-1:0]    r_xa, r_xb, r_ya, r_yb, r_za, r_zb, r_wa, r_wb;
    logic signed [SUM_W-1:0]   w_sum_x, w_sum_y, w_sum_z, w_sum_w;
    logic signed [e2q_pkg::QUAT_W-1:0] r_qx, r_qy, r_qz, r_qw;

    // advance the whole pipe unless a finished word is held by the receiver
    assign w_en  = !r_out_valid || !i_stall;
    assign o_pop = w_en && !i_queue.empty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld       <= '0;
            r_out_valid <= 1'b0;
        end else if (w_en) begin
            r_vld       <= {r_vld[PIPE_DEPTH-2:0], o_pop};
            r_out_valid <= r_vld[PIPE_DEPTH-1];
        end
    end

    e2q_cordic u_cordic_roll (
        .i_clk   (i_clk),
        .i_en    (w_en),
        .i_phase (i_head.roll),
        .o_sin   (w_sr),
        .o_cos   (w_cr)
    );

    e2q_cordic u_cordic_yaw (
        .i_clk   (i_clk),
        .i_en    (w_en),
        .i_phase (i_head.yaw),
        .o_sin   (w_sy),
        .o_cos   (w_cy)
    );

    e2q_cordic u_cordic_pitch (
        .i_clk   (i_clk),
        .i_en    (w_en),
        .i_phase (i_head.pitch),
        .o_sin   (w_sp),
        .o_cos   (w_cp)
    );

    // yaw-pitch pair products, carry roll alongside
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_cycp <= w_cy * w_cp;
            r_sysp <= w_sy * w_sp;
            r_sycp <= w_sy * w_cp;
            r_cysp <= w_cy * w_sp;
            r_sr   <= w_sr;
            r_cr   <= w_cr;
        end
    end

    // roll times pair products
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_xa <= r_sr * r_cycp;
            r_xb <= r_cr * r_sysp;
            r_ya <= r_cr * r_sycp;
            r_yb <= r_sr * r_cysp;
            r_za <= r_cr * r_cysp;
            r_zb <= r_sr * r_sycp;
            r_wa <= r_cr * r_cycp;
            r_wb <= r_sr * r_sysp;
        end
    end

    assign w_sum_x = SUM_W'(r_xa) - SUM_W'(r_xb) + e2q_pkg::Q_ROUND;
    assign w_sum_y = SUM_W'(r_ya) + SUM_W'(r_yb) + e2q_pkg::Q_ROUND;
    assign w_sum_z = SUM_W'(r_za) - SUM_W'(r_zb) + e2q_pkg::Q_ROUND;
    assign w_sum_w = SUM_W'(r_wa) + SUM_W'(r_wb) + e2q_pkg::Q_ROUND;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_qx <= e2q_pkg::clamp_one(w_sum_x >>> e2q_pkg::Q_SHIFT);
            r_qy <= e2q_pkg::clamp_one(w_sum_y >>> e2q_pkg::Q_SHIFT);
            r_qz <= e2q_pkg::clamp_one(w_sum_z >>> e2q_pkg::Q_SHIFT);
            r_qw <= e2q_pkg::clamp_one(w_sum_w >>> e2q_pkg::Q_SHIFT);
        end
    end

    assign o_valid  = r_out_valid;
    assign o_quat_x = r_qx;
    assign o_quat_y = r_qy;
    assign o_quat_z = r_qz;
    assign o_quat_w = r_qw;

    `E2Q_ASSERT_IMPLY(a_x_in_range, o_valid, (o_quat_x <= e2q_pkg::Q_ONE_SC) && (o_quat_x >= -e2q_pkg::Q_ONE_SC), "x beyond one")
    `E2Q_ASSERT_IMPLY(a_w_in_range, o_valid, (o_quat_w <= e2q_pkg::Q_ONE_SC) && (o_quat_w >= -e2q_pkg::Q_ONE_SC), "w beyond one")
    `E2Q_ASSERT_NEXT(a_hold_stalled, o_valid && i_stall, o_valid && $stable(o_quat_x) && $stable(o_quat_w), "stalled word changed")

endmodule

// File: src/euler_to_quaternion_top.sv
// Euler angles to quaternion converter, top level.
// Uses e2q_pkg, e2q_front, e2q_fifo and e2q_back (which holds e2q_cordic).
//
// Input channel: i_valid / o_stall carry one word of three angles (roll, yaw,
// pitch), signed Q3.12 radians; a word is taken at a rising edge with i_valid
// high and o_stall low. Output channel: o_valid / i_stall carry one word of
// four quaternion components (x, y, z, w), signed Q1.14 and saturated to plus
// or minus one; a word leaves at an edge with o_valid high and i_stall low.
// Every input word yields exactly one output word, in order.
//
// Path from acceptance to o_valid: the phase multiply register, the queue
// entry, 16 CORDIC iterations, the rounding register, 2 product stages, then
// the output register. Throughput: one word per cycle while the receiver does
// not stall; the three 16-stage CORDIC pipelines and the product stages each
// take a new word every cycle unless the back pipe is frozen.
//
// Reset (synchronous, active low) empties the queue and clears every valid bit.
// While the receiver stalls a valid word, that word holds and the back pipe
// freezes; the front keeps taking words into the 4-entry queue until it fills,
// then raises o_stall.
module euler_to_quaternion_top (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_valid,
    output logic                                o_stall,
    input  logic signed [e2q_pkg::ANGLE_W-1:0]  i_roll_angle,
    input  logic signed [e2q_pkg::ANGLE_W-1:0]  i_yaw_angle,
    input  logic signed [e2q_pkg::ANGLE_W-1:0]  i_pitch_angle,
    output logic                                o_valid,
    input  logic                                i_stall,
    output logic signed [e2q_pkg::QUAT_W-1:0]   o_quat_x,
    output logic signed [e2q_pkg::QUAT_W-1:0]   o_quat_y,
    output logic signed [e2q_pkg::QUAT_W-1:0]   o_quat_z,
    output logic signed [e2q_pkg::QUAT_W-1:0]   o_quat_w
);

    e2q_pkg::t_queue_status  w_queue;
    e2q_pkg::t_angles        w_push_data;
    e2q_pkg::t_angles        w_head;
    logic                    w_push;
    logic                    w_pop;

    // front: scale each half angle to a phase index
    e2q_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_stall       (o_stall),
        .i_roll_angle  (i_roll_angle),
        .i_yaw_angle   (i_yaw_angle),
        .i_pitch_angle (i_pitch_angle),
        .i_queue       (w_queue),
        .o_push        (w_push),
        .o_data        (w_push_data)
    );

    // queue: absorb back-end stalls
    e2q_fifo u_fifo (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (w_push),
        .i_data   (w_push_data),
        .i_pop    (w_pop),
        .o_head   (w_head),
        .o_status (w_queue)
    );

    // back: sine and cosine, triple products, rounding, output register
    e2q_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_head   (w_head),
        .i_queue  (w_queue),
        .o_pop    (w_pop),
        .o_valid  (o_valid),
        .i_stall  (i_stall),
        .o_quat_x (o_quat_x),
        .o_quat_y (o_quat_y),
        .o_quat_z (o_quat_z),
        .o_quat_w (o_quat_w)
    );

endmodule

// File: dv/testbench.sv
`timescale 1ns / 1ps
// Self-checking testbench for euler_to_quaternion_top: a bit-exact predictor of the
// half-angle CORDIC and the triple-product quaternion, held in a small scoreboard class.
// Depends on e2q_pkg and the RTL of the block; reads no files.
module testbench;

    typedef logic signed [e2q_pkg::ANGLE_W-1:0] t_angle;
    typedef logic signed [e2q_pkg::QUAT_W-1:0]  t_comp;

    typedef struct packed {
        t_comp x;
        t_comp y;
        t_comp z;
        t_comp w;
    } t_quat;

    // quadrant of a phase in one full turn
    typedef enum logic [1:0] {
        QUAD_FIRST,
        QUAD_SECOND,
        QUAD_THIRD,
        QUAD_FOURTH
    } t_quadrant;

    localparam int     TABLE_BITS  = e2q_pkg::SINE_TABLE_BITS;
    localparam int     PHASE_SH    = 45 - TABLE_BITS;
    localparam longint RAD_TO_TURN = 683565276;   // round(2^32 / (2*pi))
    localparam longint GAIN_INV    = 652032874;   // inverse CORDIC gain, Q2.30
    localparam int     ROT_STEPS   = 16;
    localparam longint ONE_Q14     = 16384;
    localparam longint ATAN_TURN [ROT_STEPS] = '{
        536870912, 316933406, 167458907, 85004756,
        42667331,  21354465,  10680862,  5340245,
        2670163,   1335087,   667544,    333772,
        166886,    83443,     41722,     20861
    };

    localparam int CYCLE_LIMIT   = 400000;
    localparam int DRAIN_CYCLES  = 40;     // longer than the latency of the block
    localparam int PHASE_WORDS   = 360;
    localparam int QUARTER_TURN  = 6434;   // pi/2 in Q3.12

    // Scoreboard: turns each accepted angle word into the expected quaternion
    // and checks output words against those expectations in order.
    class t_quat_scoreboard;
        t_quat pending_quats[$];
        int    fail_count;

        function new();
            fail_count = 0;
        endfunction

        function longint sat_one(input longint v);
            if (v > ONE_Q14) begin
                return ONE_Q14;
            end
            if (v < -ONE_Q14) begin
                return -ONE_Q14;
            end
            return v;
        endfunction

        // sine and cosine (Q1.14) of half the angle (Q3.12)
        function void half_sin_cos(input longint angle, output longint sin_q14,
                                   output longint cos_q14);
            longint    prod;
            longint    phase_idx;
            longint    x;
            longint    y;
            longint    z;
            longint    dx;
            longint    dy;
            longint    cr;
            longint    sr;
            logic [31:0] ph;
            t_quadrant quad;
            prod = angle * RAD_TO_TURN;
            // bias keeps the sum positive; round half up, then wrap to one turn
            phase_idx = (prod + (longint'(1) << 50) + (longint'(1) << (PHASE_SH - 1)))
                        >>> PHASE_SH;
            phase_idx = phase_idx & ((longint'(1) << TABLE_BITS) - 1);
            ph = 32'(phase_idx << (32 - TABLE_BITS));
            quad = t_quadrant'(ph[31:30]);
            z = longint'(ph[29:0]);
            x = GAIN_INV;
            y = 0;
            for (int i = 0; i < ROT_STEPS; i++) begin
                dx = y >>> i;
                dy = x >>> i;
                if (z >= 0) begin
                    x = x - dx;
                    y = y + dy;
                    z = z - ATAN_TURN[i];
                end else begin
                    x = x + dx;
                    y = y - dy;
                    z = z + ATAN_TURN[i];
                end
            end
            case (quad)
                QUAD_FIRST: begin
                    cr = x;
                    sr = y;
                end
                QUAD_SECOND: begin
                    cr = -y;
                    sr = x;
                end
                QUAD_THIRD: begin
                    cr = -x;
                    sr = -y;
                end
                default: begin
                    cr = y;
                    sr = -x;
                end
            endcase
            cos_q14 = sat_one((cr + 32768) >>> 16);
            sin_q14 = sat_one((sr + 32768) >>> 16);
        endfunction

        // round a Q.42 sum of triple products to Q1.14 and saturate
        function t_comp round_q14(input longint sum42);
            return t_comp'(sat_one((sum42 + (longint'(1) << 27)) >>> 28));
        endfunction

        function void note_angles(input t_angle roll, input t_angle yaw, input t_angle pitch);
            longint sr;
            longint cr;
            longint sy;
            longint cy;
            longint sp;
            longint cp;
            t_quat  q;
            half_sin_cos(longint'(roll), sr, cr);
            half_sin_cos(longint'(yaw), sy, cy);
            half_sin_cos(longint'(pitch), sp, cp);
            q.x = round_q14(sr * cy * cp - cr * sy * sp);
            q.y = round_q14(cr * sy * cp + sr * cy * sp);
            q.z = round_q14(cr * cy * sp - sr * sy * cp);
            q.w = round_q14(cr * cy * cp + sr * sy * sp);
            pending_quats.push_back(q);
        endfunction

        function void compare_comp(input string name, input t_comp want, input t_comp got);
            if (want !== got) begin
                $error("%s mismatch: expected %0d, got %0d", name, want, got);
                fail_count++;
            end
        endfunction

        function void check_quat(input t_quat got);
            t_quat want;
            if (pending_quats.size() == 0) begin
                $error("quaternion word with no expectation pending: x=%0d y=%0d z=%0d w=%0d",
                       got.x, got.y, got.z, got.w);
                fail_count++;
                return;
            end
            want = pending_quats.pop_front();
            compare_comp("quat_x", want.x, got.x);
            compare_comp("quat_y", want.y, got.y);
            compare_comp("quat_z", want.z, got.z);
            compare_comp("quat_w", want.w, got.w);
        endfunction

        function int pending_count();
            return pending_quats.size();
        endfunction
    endclass

    // ------------------------------------------------------------------
    // Clock, reset and block
    // ------------------------------------------------------------------
    logic   i_clk         = 1'b0;
    logic   i_rst_n       = 1'b0;
    logic   i_valid       = 1'b0;
    logic   i_stall       = 1'b0;
    t_angle i_roll_angle  = '0;
    t_angle i_yaw_angle   = '0;
    t_angle i_pitch_angle = '0;
    logic   o_stall;
    logic   o_valid;
    t_comp  o_quat_x;
    t_comp  o_quat_y;
    t_comp  o_quat_z;
    t_comp  o_quat_w;

    t_quat_scoreboard quat_sb;
    int send_idle_pct = 0;   // chance in a hundred that the sender idles a cycle
    int recv_stall_pct = 0;  // chance in a hundred that the receiver stalls a cycle
    int cycle_count = 0;

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    euler_to_quaternion_top i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_stall       (o_stall),
        .i_roll_angle  (i_roll_angle),
        .i_yaw_angle   (i_yaw_angle),
        .i_pitch_angle (i_pitch_angle),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_quat_x      (o_quat_x),
        .o_quat_y      (o_quat_y),
        .o_quat_z      (o_quat_z),
        .o_quat_w      (o_quat_w)
    );

    // ------------------------------------------------------------------
    // Sender side
    // ------------------------------------------------------------------

    // Offer one angle word and hold it until the block takes it. Entered right
    // after an edge; valid is only ever lowered during an idle cycle, so a word
    // that follows another directly keeps valid high without a glitch.
    task automatic send_angles(input t_angle roll, input t_angle yaw, input t_angle pitch);
        while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid       <= 1'b1;
        i_roll_angle  <= roll;
        i_yaw_angle   <= yaw;
        i_pitch_angle <= pitch;
        // o_stall read here is the value the block saw at this edge
        do begin
            @(posedge i_clk);
        end while (o_stall);
        quat_sb.note_angles(roll, yaw, pitch);
    endtask

    // Drop valid and hold off until every expected quaternion has come out.
    task automatic drain_pipe();
        i_valid <= 1'b0;
        while (quat_sb.pending_count() != 0) begin
            @(posedge i_clk);
        end
    endtask

    // Random angle: mostly raw 16-bit patterns, plus small angles (coarse phase
    // steps and the rounding edge), angles near quarter turns and the extremes.
    function automatic t_angle pick_angle();
        int sel;
        sel = $urandom_range(9);
        case (sel)
            5, 6: return t_angle'(int'($urandom_range(400)) - 200);
            7: return t_angle'((int'($urandom_range(10)) - 5) * QUARTER_TURN
                               + int'($urandom_range(16)) - 8);
            8: begin
                case ($urandom_range(4))
                    0: return t_angle'(32767);
                    1: return t_angle'(-32768);
                    2: return t_angle'(0);
                    3: return t_angle'(1);
                    default: return t_angle'(-1);
                endcase
            end
            default: return t_angle'($urandom);
        endcase
    endfunction

    // ------------------------------------------------------------------
    // Receiver side: check each word that leaves, then pick the next stall
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) begin
            quat_sb.check_quat('{x: o_quat_x, y: o_quat_y, z: o_quat_z, w: o_quat_w});
        end
        i_stall <= (recv_stall_pct != 0) && ($urandom_range(99) < recv_stall_pct);
    end

    // Run watchdog: a hung handshake ends the run here.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("testbench NOT OK");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------
    initial begin
        int sender_pcts [4];
        int recv_pcts [4];
        sender_pcts = '{0, 71, 0, 38};
        recv_pcts   = '{0, 0, 71, 38};
        quat_sb = new();
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: zero, extremes, sign flips, the coarsest phase steps
        // (rounding edge near 25), quarter and half turns, and near-unit cosines
        // where a component can overshoot one and saturate.
        send_angles(t_angle'(0), t_angle'(0), t_angle'(0));
        send_angles(t_angle'(32767), t_angle'(32767), t_angle'(32767));
        send_angles(t_angle'(-32768), t_angle'(-32768), t_angle'(-32768));
        send_angles(t_angle'(32767), t_angle'(-32768), t_angle'(0));
        send_angles(t_angle'(-32768), t_angle'(0), t_angle'(32767));
        send_angles(t_angle'(1), t_angle'(-1), t_angle'(1));
        send_angles(t_angle'(-1), t_angle'(-1), t_angle'(-1));
        send_angles(t_angle'(25), t_angle'(26), t_angle'(-25));
        send_angles(t_angle'(50), t_angle'(50), t_angle'(50));
        send_angles(t_angle'(-50), t_angle'(50), t_angle'(-50));
        send_angles(t_angle'(100), t_angle'(100), t_angle'(100));
        send_angles(t_angle'(6434), t_angle'(0), t_angle'(0));
        send_angles(t_angle'(0), t_angle'(6434), t_angle'(0));
        send_angles(t_angle'(0), t_angle'(0), t_angle'(6434));
        send_angles(t_angle'(12868), t_angle'(-12868), t_angle'(12868));
        send_angles(t_angle'(25736), t_angle'(25736), t_angle'(-25736));
        send_angles(t_angle'(-6434), t_angle'(19302), t_angle'(-19302));
        send_angles(t_angle'(16'h5555), t_angle'(16'hAAAA), t_angle'(16'h5555));
        send_angles(t_angle'(16'hAAAA), t_angle'(16'h5555), t_angle'(16'hAAAA));
        send_angles(t_angle'(3217), t_angle'(-3217), t_angle'(9651));
        drain_pipe();

        // Random phases: clean streaming, idle sender, stalling receiver, both.
        // Drain between phases so the sender also waits on an empty pipe.
        for (int ph = 0; ph < 4; ph++) begin
            send_idle_pct  = sender_pcts[ph];
            recv_stall_pct = recv_pcts[ph];
            for (int n = 0; n < PHASE_WORDS; n++) begin
                send_angles(pick_angle(), pick_angle(), pick_angle());
            end
            drain_pipe();
        end

        // Let the block settle, then confirm nothing extra comes out.
        recv_stall_pct = 0;
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (quat_sb.pending_count() != 0) begin
            $error("%0d quaternion words never arrived", quat_sb.pending_count());
            quat_sb.fail_count++;
        end
        if (quat_sb.fail_count == 0) begin
            $display("testbench OK");
        end else begin
            $display("testbench NOT OK");
        end
        $finish;
    end

endmodule

// File: filelist.f
+incdir+src
src/e2q_pkg.sv
src/e2q_front.sv
src/e2q_fifo.sv
src/e2q_cordic.sv
src/e2q_back.sv
src/euler_to_quaternion_top.sv
dv/testbench.sv
